/* rtl/bpcs_pkg.sv */
// Shared types, codes and helper functions for the bus poll command scheduler.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bpcs_pkg;

  // Event kinds carried by one input word
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WDONE = 2'd1;
  localparam logic [1:0] REQ_RDONE = 2'd2;
  localparam logic [1:0] REQ_POST  = 2'd3;

  // Bus actions reported in the result word
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_RESET = 2'd3;

  // Register select (paddr bit 2)
  localparam logic REG_WDOG_LIMIT = 1'b0;
  localparam logic REG_ERR_LIMIT  = 1'b1;

  // Register reset values
  localparam logic [7:0] WDOG_LIMIT_RST = 8'd10;
  localparam logic [7:0] ERR_LIMIT_RST  = 8'd5;

  // Operation in flight on the bus
  typedef enum logic [2:0] {
    OPK_IDLE = 3'b001,
    OPK_POLL = 3'b010,
    OPK_CMD  = 3'b100
  } op_kind_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       start_refused;
    logic [5:0] byte_count;
    logic [6:0] dest_addr;
  } item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] poll_slot;
    logic [6:0] cmd_dest;
    logic [5:0] cmd_len;
    logic [7:0] error_count;
    logic [7:0] poll_round;
    logic       post_accepted;
  } result_t;

  typedef struct packed {
    logic [7:0] wdog_limit;
    logic [7:0] err_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] count;
    logic       bus_reset;
  } err_step_t;

  typedef struct packed {
    logic [1:0] slot;
    logic [7:0] round;
  } slot_adv_t;

  // Saturating error count; crossing the limit asks for a bus reset
  function automatic err_step_t err_step(logic [7:0] cnt, logic [7:0] lim);
    err_step_t r;
    r.count     = (cnt != 8'hFF) ? cnt + 8'd1 : cnt;
    r.bus_reset = 1'b0;
    if (r.count > lim) begin
      r.count     = 8'd0;
      r.bus_reset = 1'b1;
    end
    return r;
  endfunction

  // Round-robin slot step; wrapping counts one completed round
  function automatic slot_adv_t slot_advance(logic [1:0] slot, logic [7:0] round,
                                             logic [1:0] step, logic [2:0] slots);
    slot_adv_t  r;
    logic [2:0] s;
    s       = {1'b0, slot} + {1'b0, step};
    r.round = round;
    if (s >= slots) begin
      s       = 3'd0;
      r.round = round + 8'd1;
    end
    r.slot = s[1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/bpcs_cfg_regs.sv */
// APB-style configuration registers: watchdog limit and error limit.
// Depends on bpcs_pkg for register codes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module bpcs_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output bpcs_pkg::cfg_t    cfg
);
  import bpcs_pkg::*;

  logic [7:0] wdog_limit_r;
  logic [7:0] err_limit_r;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wdog_limit_r <= WDOG_LIMIT_RST;
      err_limit_r  <= ERR_LIMIT_RST;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_WDOG_LIMIT: wdog_limit_r <= cfg_pwdata[7:0];
        REG_ERR_LIMIT:  err_limit_r  <= cfg_pwdata[7:0];
        default:        ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    cfg_prdata = 32'd0;
    unique case (cfg_paddr[2])
      REG_WDOG_LIMIT: cfg_prdata = {24'd0, wdog_limit_r};
      REG_ERR_LIMIT:  cfg_prdata = {24'd0, err_limit_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.wdog_limit = wdog_limit_r;
  assign cfg.err_limit  = err_limit_r;

endmodule

`default_nettype wire

/* rtl/bpcs_sched.sv */
// Scheduler state and the per-event next-state logic.
// Depends on bpcs_pkg; the top level supplies the registered event word.
`timescale 1ns / 1ps
`default_nettype none

module bpcs_sched #(
  parameter int POLL_SLOTS       = 3,
  parameter int CMD_BUFFER_BYTES = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step_en,
  input  bpcs_pkg::item_t      item,
  input  bpcs_pkg::cfg_t       cfg,
  output bpcs_pkg::result_t    res
);
  import bpcs_pkg::*;

  localparam logic [2:0] SLOTS   = 3'(POLL_SLOTS);
  localparam logic [5:0] CMD_MAX = 6'(CMD_BUFFER_BYTES);

  logic [1:0] slot_r,  slot_nxt;
  op_kind_t   op_r,    op_nxt;
  logic [7:0] wdog_r,  wdog_nxt;
  logic [7:0] err_r,   err_nxt;
  logic [5:0] plen_r,  plen_nxt;
  logic [6:0] pdest_r, pdest_nxt;
  logic [7:0] round_r, round_nxt;

  // Event evaluation against current state
  always_comb begin
    logic [1:0] action;
    logic       accepted;
    slot_adv_t  adv;
    err_step_t  es;

    slot_nxt  = slot_r;
    op_nxt    = op_r;
    wdog_nxt  = wdog_r;
    err_nxt   = err_r;
    plen_nxt  = plen_r;
    pdest_nxt = pdest_r;
    round_nxt = round_r;
    action    = ACT_NONE;
    accepted  = 1'b0;
    adv       = '0;
    es        = '0;

    unique case (item.req_type)
      REQ_TICK: begin
        wdog_nxt = wdog_r + 8'd1;
        if (wdog_nxt == cfg.wdog_limit) begin
          // watchdog expiry: force a bus reset
          if (op_r != OPK_CMD) begin
            adv       = slot_advance(slot_r, round_r, 2'd1, SLOTS);
            slot_nxt  = adv.slot;
            round_nxt = adv.round;
          end
          op_nxt  = OPK_IDLE;
          err_nxt = 8'd0;
          action  = ACT_RESET;
        end else if (op_r == OPK_IDLE) begin
          wdog_nxt = 8'd0;
          if (plen_r != 6'd0) begin
            op_nxt = OPK_CMD;
            action = ACT_WRITE;
          end else if ({1'b0, slot_r} < SLOTS) begin
            op_nxt = OPK_POLL;
            action = ACT_READ;
          end else begin
            slot_nxt = 2'd0;
          end
          // bus engine refused the transfer just issued
          if (action != ACT_NONE && item.start_refused) begin
            op_nxt  = OPK_IDLE;
            es      = err_step(err_r, cfg.err_limit);
            err_nxt = es.count;
            if (es.bus_reset) action = ACT_RESET;
          end
        end
      end
      REQ_WDONE: begin
        if (item.byte_count != 6'd0) begin
          if (op_r == OPK_POLL) begin
            adv       = slot_advance(slot_r, round_r, 2'd1, SLOTS);
            slot_nxt  = adv.slot;
            round_nxt = adv.round;
          end else begin
            plen_nxt = 6'd0;
          end
        end else begin
          es      = err_step(err_r, cfg.err_limit);
          err_nxt = es.count;
          if (es.bus_reset) action = ACT_RESET;
          if (op_r == OPK_POLL) begin
            adv       = slot_advance(slot_r, round_r, 2'd2, SLOTS);
            slot_nxt  = adv.slot;
            round_nxt = adv.round;
          end
        end
        op_nxt = OPK_IDLE;
      end
      REQ_RDONE: begin
        if (op_r == OPK_POLL) begin
          adv       = slot_advance(slot_r, round_r, 2'd1, SLOTS);
          slot_nxt  = adv.slot;
          round_nxt = adv.round;
        end
        op_nxt = OPK_IDLE;
        if (item.byte_count == 6'd0) begin
          es      = err_step(err_r, cfg.err_limit);
          err_nxt = es.count;
          if (es.bus_reset) action = ACT_RESET;
        end
      end
      REQ_POST: begin
        // store only when no command is pending; clamp to buffer size
        if (plen_r == 6'd0) begin
          plen_nxt  = (item.byte_count > CMD_MAX) ? CMD_MAX : item.byte_count;
          pdest_nxt = item.dest_addr;
          accepted  = 1'b1;
        end
      end
      default: ;
    endcase

    res.action        = action;
    res.poll_slot     = slot_nxt;
    res.cmd_dest      = pdest_nxt;
    res.cmd_len       = plen_nxt;
    res.error_count   = err_nxt;
    res.poll_round    = round_nxt;
    res.post_accepted = accepted;
  end

  // State update, one event per enabled cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= 2'd0;
      op_r    <= OPK_IDLE;
      wdog_r  <= 8'd0;
      err_r   <= 8'd0;
      plen_r  <= 6'd0;
      pdest_r <= 7'd0;
      round_r <= 8'd0;
    end else if (step_en) begin
      slot_r  <= slot_nxt;
      op_r    <= op_nxt;
      wdog_r  <= wdog_nxt;
      err_r   <= err_nxt;
      plen_r  <= plen_nxt;
      pdest_r <= pdest_nxt;
      round_r <= round_nxt;
    end
  end

  // Slot never leaves the configured range
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, slot_r} < SLOTS)
    else $error("poll slot out of range");

  // Pending length is bounded by the command buffer
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= CMD_MAX)
    else $error("pending command longer than buffer");

  // A post that was taken found no command pending
  a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.post_accepted |-> plen_r == 6'd0)
    else $error("post stored over a pending command");

  // Watchdog counter is cleared whenever an idle tick issues a poll read
  a_wdog_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.req_type == REQ_TICK && res.action == ACT_READ |=> wdog_r == 8'd0)
    else $error("watchdog not cleared on issue");

endmodule

`default_nettype wire

/* rtl/bus_poll_command_scheduler.sv */
// An accepted word is held in the input register, then evaluated and written
// to the result register. Throughput: one word per cycle; input register,
// single-pass event logic, result register. in_ready drops only while both
// registers hold words and the result word is not being taken.
// Reset (rst_n low, synchronous): pipeline empty, scheduler idle at slot 0,
// counters and pending command cleared, limits back to 10 and 5.
// Depends on bpcs_pkg, bpcs_cfg_regs and bpcs_sched.
`timescale 1ns / 1ps
`default_nettype none

module bus_poll_command_scheduler #(
  parameter int POLL_SLOTS       = 3,
  parameter int CMD_BUFFER_BYTES = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // event channel
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   in_req_type,
  input  wire logic         in_start_refused,
  input  wire logic [5:0]   in_byte_count,
  input  wire logic [6:0]   in_dest_addr,
  // result channel
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [1:0]        out_action,
  output logic [1:0]        out_poll_slot,
  output logic [6:0]        out_cmd_dest,
  output logic [5:0]        out_cmd_len,
  output logic [7:0]        out_error_count,
  output logic [7:0]        out_poll_round,
  output logic              out_post_accepted,
  // configuration
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import bpcs_pkg::*;

  cfg_t    cfg;
  item_t   in_word_r;
  logic    in_valid_r;
  result_t res;
  result_t out_word_r;
  logic    out_valid_r;
  logic    step_en;

  bpcs_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Event is processed when the result register is free or draining
  assign step_en  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step_en;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r.req_type      <= in_req_type;
      in_word_r.start_refused <= in_start_refused;
      in_word_r.byte_count    <= in_byte_count;
      in_word_r.dest_addr     <= in_dest_addr;
    end
  end

  bpcs_sched #(
    .POLL_SLOTS       (POLL_SLOTS),
    .CMD_BUFFER_BYTES (CMD_BUFFER_BYTES)
  ) u_sched (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_word_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_word_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = out_word_r.action;
  assign out_poll_slot     = out_word_r.poll_slot;
  assign out_cmd_dest      = out_word_r.cmd_dest;
  assign out_cmd_len       = out_word_r.cmd_len;
  assign out_error_count   = out_word_r.error_count;
  assign out_poll_round    = out_word_r.poll_round;
  assign out_post_accepted = out_word_r.post_accepted;

  // Ready only drops while the input register holds a stalled word
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full pipeline");

  // Every bus reset leaves the error count cleared
  a_reset_clears_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.action == ACT_RESET |-> out_word_r.error_count == 8'd0)
    else $error("bus reset with nonzero error count");

  // Only a post reports an accepted command
  a_accept_kind: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.post_accepted |-> in_word_r.req_type == REQ_POST)
    else $error("accept flag on non-post event");

endmodule

`default_nettype wire
